// ===== rtl/pidci_pkg.sv =====
// ----------------------------------------------------------------------------
// PID conditional-integration package
// Shared widths, payload structs, register indexes and the microcode ROM of
// the sequenced PID datapath.
// ----------------------------------------------------------------------------
package pidci_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int ERR_W      = SAMPLE_W + 1;
    localparam int DIFF_W     = SAMPLE_W + 2;
    localparam int SUM_W      = 32;
    localparam int GAIN_W     = 16;
    localparam int DIV_W      = 16;
    localparam int LIM_W      = 15;
    localparam int DRIVE_W    = 16;
    localparam int ACC_W      = 48;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int PC_W       = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KP_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_DIVISOR = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_OUTPUT  = 3'd4;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] setpoint;
        logic signed [SAMPLE_W-1:0] feedback;
    } in_t;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] drive;
        logic                      saturated;
    } out_t;

    typedef enum logic [1:0] {
        GSEL_KP,
        GSEL_KI,
        GSEL_KD
    } gain_sel_t;

    typedef enum logic [1:0] {
        OSEL_ERR,
        OSEL_DIFF,
        OSEL_SUM
    } opnd_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [1:0] {
        JMP_NONE,
        JMP_NO_INPUT,
        JMP_DIV_BUSY,
        JMP_OUT_FULL
    } jmp_t;

    typedef struct packed {
        logic             accept;
        logic             mul_en;
        gain_sel_t        gain_sel;
        opnd_sel_t        opnd_sel;
        acc_op_t          acc_op;
        logic             div_start;
        logic             finish;
        jmp_t             jmp;
        logic [PC_W-1:0]  target;
    } ucode_t;

    // Step addresses
    localparam logic [PC_W-1:0] UC_IDLE  = 3'd0;
    localparam logic [PC_W-1:0] UC_MUL_P = 3'd1;
    localparam logic [PC_W-1:0] UC_MUL_D = 3'd2;
    localparam logic [PC_W-1:0] UC_MUL_I = 3'd3;
    localparam logic [PC_W-1:0] UC_ACC   = 3'd4;
    localparam logic [PC_W-1:0] UC_DIV   = 3'd5;
    localparam logic [PC_W-1:0] UC_WAIT  = 3'd6;
    localparam logic [PC_W-1:0] UC_DONE  = 3'd7;

    // Microcode ROM: a taken jump goes to target, otherwise step to pc + 1.
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t uc;
        uc = '{accept: 1'b0, mul_en: 1'b0, gain_sel: GSEL_KP, opnd_sel: OSEL_ERR,
               acc_op: ACC_HOLD, div_start: 1'b0, finish: 1'b0, jmp: JMP_NONE,
               target: UC_IDLE};
        unique case (pc)
            UC_IDLE: begin
                uc.accept = 1'b1;
                uc.jmp    = JMP_NO_INPUT;
                uc.target = UC_IDLE;
            end
            UC_MUL_P: begin
                uc.mul_en   = 1'b1;
                uc.gain_sel = GSEL_KP;
                uc.opnd_sel = OSEL_ERR;
            end
            UC_MUL_D: begin
                uc.mul_en   = 1'b1;
                uc.gain_sel = GSEL_KD;
                uc.opnd_sel = OSEL_DIFF;
                uc.acc_op   = ACC_LOAD;
            end
            UC_MUL_I: begin
                uc.mul_en   = 1'b1;
                uc.gain_sel = GSEL_KI;
                uc.opnd_sel = OSEL_SUM;
                uc.acc_op   = ACC_ADD;
            end
            UC_ACC: begin
                uc.acc_op = ACC_ADD;
            end
            UC_DIV: begin
                uc.div_start = 1'b1;
            end
            UC_WAIT: begin
                uc.jmp    = JMP_DIV_BUSY;
                uc.target = UC_WAIT;
            end
            UC_DONE: begin
                uc.finish = 1'b1;
                uc.jmp    = JMP_OUT_FULL;
                uc.target = UC_DONE;
            end
        endcase
        return uc;
    endfunction

endpackage

// ===== rtl/pidci_div.sv =====
// ----------------------------------------------------------------------------
// PID serial divider
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module pidci_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [pidci_pkg::ACC_W-1:0] dividend,
    input  logic [pidci_pkg::DIV_W-1:0] divisor,
    output logic                        busy,
    output logic [pidci_pkg::ACC_W-1:0] quotient
);

    localparam int QW    = pidci_pkg::ACC_W;
    localparam int DW    = pidci_pkg::DIV_W;
    localparam int STEPS = QW / 2;
    localparam int CNT_W = $clog2(STEPS);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [QW-1:0]    quo_reg, quo_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    dsr_reg, dsr_next;

    logic [DW:0] t1, t2, r1, r2;
    logic        ge1, ge2;

    always_comb begin
        t1  = {rem_reg, quo_reg[QW-1]};
        ge1 = t1 >= {1'b0, dsr_reg};
        r1  = ge1 ? t1 - {1'b0, dsr_reg} : t1;
        t2  = {r1[DW-1:0], quo_reg[QW-2]};
        ge2 = t2 >= {1'b0, dsr_reg};
        r2  = ge2 ? t2 - {1'b0, dsr_reg} : t2;

        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[QW-3:0], ge1, ge2};
            rem_next = r2[DW-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/pid_conditional_integration.sv =====
// ----------------------------------------------------------------------------
// PID controller with conditional-integration anti-windup
// Microcoded fixed-point PID: one shared multiplier, one accumulator and a
// serial divider, sequenced by a small control ROM.
// ----------------------------------------------------------------------------
//
//  channel  | ports                          | moves
//  ---------+--------------------------------+---------------------------------
//  input    | s_valid, s_ready, s_data       | setpoint and feedback sample
//  result   | m_valid, m_ready, m_data       | clamped drive and saturated flag
//  config   | cfg_wr_en, cfg_index, cfg_data | gain, divisor and limit writes
//
//  A transaction runs from acceptance to result through one accept step,
//  four multiply/accumulate steps, a divider start, the wait on the
//  24-step radix-4 divider until it is no longer busy, and one finish step.
//  A new transaction is taken as soon as the sequencer is back at its idle
//  step, even while the previous result still waits in the output register.
//  The finish step stalls only while that output register is still full.
//  Reset is synchronous, active low; it restores the register defaults and
//  clears the integral and the previous error.
// ----------------------------------------------------------------------------
module pid_conditional_integration (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  pidci_pkg::in_t                      s_data,

    output logic                                m_valid,
    input  logic                                m_ready,
    output pidci_pkg::out_t                     m_data,

    input  logic                                cfg_wr_en,
    input  logic [pidci_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pidci_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int ERR_W   = pidci_pkg::ERR_W;
    localparam int DIFF_W  = pidci_pkg::DIFF_W;
    localparam int SUM_W   = pidci_pkg::SUM_W;
    localparam int GAIN_W  = pidci_pkg::GAIN_W;
    localparam int DIV_W   = pidci_pkg::DIV_W;
    localparam int LIM_W   = pidci_pkg::LIM_W;
    localparam int DRIVE_W = pidci_pkg::DRIVE_W;
    localparam int ACC_W   = pidci_pkg::ACC_W;
    localparam int PC_W    = pidci_pkg::PC_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [GAIN_W-1:0] kp_reg, ki_reg, kd_reg;
    logic        [DIV_W-1:0]  divisor_reg;
    logic        [LIM_W-1:0]  max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kp_reg      <= GAIN_W'(256);
            ki_reg      <= '0;
            kd_reg      <= '0;
            divisor_reg <= DIV_W'(256);
            max_reg     <= '1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pidci_pkg::REG_KP_GAIN:     kp_reg      <= cfg_data;
                pidci_pkg::REG_KI_GAIN:     ki_reg      <= cfg_data;
                pidci_pkg::REG_KD_GAIN:     kd_reg      <= cfg_data;
                pidci_pkg::REG_OUT_DIVISOR: divisor_reg <= cfg_data;
                pidci_pkg::REG_MAX_OUTPUT:  max_reg     <= cfg_data[LIM_W-1:0];
                default: ;  // unmapped index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: program counter and control word
    // ------------------------------------------------------------------
    logic [PC_W-1:0]   pc_reg, pc_next;
    pidci_pkg::ucode_t uc;
    logic              jump_taken;
    logic              div_busy;
    logic              out_full;
    logic              in_take;
    logic              fin_en;

    // Output register state, read by the sequencer's stall condition
    logic            m_valid_reg, m_valid_next;
    pidci_pkg::out_t m_data_reg;

    assign uc       = pidci_pkg::ucode_rom(pc_reg);
    assign out_full = m_valid_reg && !m_ready;
    assign in_take  = uc.accept && s_valid;
    assign fin_en   = uc.finish && !out_full;

    always_comb begin
        unique case (uc.jmp)
            pidci_pkg::JMP_NONE:     jump_taken = 1'b0;
            pidci_pkg::JMP_NO_INPUT: jump_taken = !s_valid;
            pidci_pkg::JMP_DIV_BUSY: jump_taken = div_busy;
            pidci_pkg::JMP_OUT_FULL: jump_taken = out_full;
        endcase
        // Fall-through from the finish step wraps back to idle.
        pc_next = jump_taken ? uc.target : pc_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= pidci_pkg::UC_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign s_ready = uc.accept;

    // ------------------------------------------------------------------
    // Error, derivative difference and controller state
    // ------------------------------------------------------------------
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic signed [ERR_W-1:0]  last_err_reg, last_err_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;

    always_comb begin
        err_next  = ERR_W'(s_data.setpoint) - ERR_W'(s_data.feedback);
        diff_next = DIFF_W'(err_next) - DIFF_W'(last_err_reg);
    end

    // Capture the sample terms on acceptance; hold them for the item.
    always_ff @(posedge aclk) begin
        if (in_take) begin
            err_reg  <= err_next;
            diff_reg <= diff_next;
        end
    end

    // ------------------------------------------------------------------
    // Shared multiplier and accumulator
    // ------------------------------------------------------------------
    logic signed [GAIN_W-1:0] mul_a;
    logic signed [SUM_W-1:0]  mul_b;
    logic signed [ACC_W-1:0]  prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;

    always_comb begin
        unique case (uc.gain_sel)
            pidci_pkg::GSEL_KP: mul_a = kp_reg;
            pidci_pkg::GSEL_KI: mul_a = ki_reg;
            pidci_pkg::GSEL_KD: mul_a = kd_reg;
            default:            mul_a = '0;
        endcase
        unique case (uc.opnd_sel)
            pidci_pkg::OSEL_ERR:  mul_b = SUM_W'(err_reg);
            pidci_pkg::OSEL_DIFF: mul_b = SUM_W'(diff_reg);
            pidci_pkg::OSEL_SUM:  mul_b = sum_reg;
            default:              mul_b = '0;
        endcase
        prod_next = ACC_W'(mul_a) * ACC_W'(mul_b);

        // Sum of the three terms stays below 2^47 in magnitude.
        unique case (uc.acc_op)
            pidci_pkg::ACC_HOLD: acc_next = acc_reg;
            pidci_pkg::ACC_LOAD: acc_next = prod_reg;
            pidci_pkg::ACC_ADD:  acc_next = acc_reg + prod_reg;
            default:             acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (uc.mul_en) begin
            prod_reg <= prod_next;
        end
        acc_reg <= acc_next;
    end

    // ------------------------------------------------------------------
    // Divide the magnitude; the sign of the accumulator restores it later,
    // which gives truncation toward zero.
    // ------------------------------------------------------------------
    logic [ACC_W-1:0] acc_mag;
    logic [DIV_W-1:0] div_eff;
    logic [ACC_W-1:0] quotient;

    assign acc_mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign div_eff = (divisor_reg == '0) ? DIV_W'(1) : divisor_reg;

    pidci_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (uc.div_start),
        .dividend (acc_mag),
        .divisor  (div_eff),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // ------------------------------------------------------------------
    // Clamp, conditional integration and result
    // ------------------------------------------------------------------
    logic                      sat;
    logic [DRIVE_W-1:0]        mag_sel;
    logic signed [DRIVE_W-1:0] drive_val;
    logic signed [SUM_W:0]     sum_wide;

    always_comb begin
        // Reaching the limit exactly counts as clamped.
        sat     = quotient >= ACC_W'(max_reg);
        mag_sel = sat ? DRIVE_W'(max_reg) : DRIVE_W'(quotient[LIM_W-1:0]);
        drive_val = acc_reg[ACC_W-1] ? DRIVE_W'(-mag_sel) : DRIVE_W'(mag_sel);

        // Saturating integral update, skipped while clamped.
        sum_wide = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(err_reg);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                       : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sum_next = sum_wide[SUM_W-1:0];
        end
        if (sat) begin
            sum_next = sum_reg;
        end

        last_err_next = err_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_err_reg <= '0;
            sum_reg      <= '0;
        end else if (fin_en) begin
            last_err_reg <= last_err_next;
            sum_reg      <= sum_next;
        end
    end

    // Output register: load on finish, drop valid once the result is taken.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (fin_en) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_en) begin
            m_data_reg.drive     <= drive_val;
            m_data_reg.saturated <= sat;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== test/pidci_checker.sv =====
// ----------------------------------------------------------------------------
// PID conditional-integration checker
// Watches the sample, result and register-write ports, runs a cycle-free
// model of the control law on every accepted sample and compares each result
// against the oldest predicted drive.
// ----------------------------------------------------------------------------
module pidci_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  pidci_pkg::in_t                      s_data,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  pidci_pkg::out_t                     m_data,
    input  logic                                cfg_wr_en,
    input  logic [pidci_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pidci_pkg::CFG_DATA_W-1:0]    cfg_data,
    output int                                  mismatch_total,
    output int                                  drives_outstanding
);

    localparam longint SUM_MAX = 64'sd2147483647;
    localparam longint SUM_MIN = -64'sd2147483648;

    logic signed [pidci_pkg::GAIN_W-1:0] kp_q;
    logic signed [pidci_pkg::GAIN_W-1:0] ki_q;
    logic signed [pidci_pkg::GAIN_W-1:0] kd_q;
    logic        [pidci_pkg::DIV_W-1:0]  div_q;
    logic        [pidci_pkg::LIM_W-1:0]  limit_q;
    logic signed [pidci_pkg::ERR_W-1:0]  prev_err;
    logic signed [pidci_pkg::SUM_W-1:0]  integ;

    pidci_pkg::out_t drive_queue[$];
    int              mismatches;

    // One controller step: returns the clamped drive and updates the
    // previous error and, when not clamped, the integral.
    function automatic pidci_pkg::out_t advance_loop(input pidci_pkg::in_t smp);
        longint          err;
        longint          diff;
        longint          divisor;
        longint          num;
        longint          drv;
        longint          lim;
        longint          acc;
        pidci_pkg::out_t res;
        err     = longint'($signed(smp.setpoint)) - longint'($signed(smp.feedback));
        diff    = err - longint'(prev_err);
        divisor = (div_q == '0) ? 64'sd1 : longint'(div_q);
        num     = longint'(kp_q) * err + longint'(kd_q) * diff
                + longint'(ki_q) * longint'(integ);
        drv     = num / divisor;
        lim     = longint'(limit_q);
        prev_err = err[pidci_pkg::ERR_W-1:0];
        res.saturated = 1'b1;
        if (drv >= lim) begin
            drv = lim;
        end else if (drv <= -lim) begin
            drv = -lim;
        end else begin
            acc = longint'(integ) + err;
            if (acc > SUM_MAX) acc = SUM_MAX;
            if (acc < SUM_MIN) acc = SUM_MIN;
            integ = acc[pidci_pkg::SUM_W-1:0];
            res.saturated = 1'b0;
        end
        res.drive = drv[pidci_pkg::DRIVE_W-1:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        pidci_pkg::out_t want;
        if (!aresetn) begin
            kp_q     = 16'sd256;
            ki_q     = '0;
            kd_q     = '0;
            div_q    = 16'd256;
            limit_q  = 15'd32767;
            prev_err = '0;
            integ    = '0;
            drive_queue.delete();
            mismatches = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    pidci_pkg::REG_KP_GAIN:     kp_q    = cfg_data;
                    pidci_pkg::REG_KI_GAIN:     ki_q    = cfg_data;
                    pidci_pkg::REG_KD_GAIN:     kd_q    = cfg_data;
                    pidci_pkg::REG_OUT_DIVISOR: div_q   = cfg_data;
                    pidci_pkg::REG_MAX_OUTPUT:  limit_q = cfg_data[pidci_pkg::LIM_W-1:0];
                    default: ;
                endcase
            end
            // compare before queuing so a stray result never meets a fresh entry
            if (m_valid && m_ready) begin
                if (drive_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: drive %0d saturated %0b",
                                 $signed(m_data.drive), m_data.saturated);
                end else begin
                    want = drive_queue.pop_front();
                    if (m_data.drive !== want.drive ||
                        m_data.saturated !== want.saturated) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("drive mismatch: expected %0d/%0b, got %0d/%0b",
                                     $signed(want.drive), want.saturated,
                                     $signed(m_data.drive), m_data.saturated);
                    end
                end
            end
            if (s_valid && s_ready)
                drive_queue.push_back(advance_loop(s_data));
        end
        mismatch_total     <= mismatches;
        drives_outstanding <= drive_queue.size();
    end

endmodule

// ===== test/tb_pid_conditional_integration.sv =====
// ----------------------------------------------------------------------------
// PID conditional-integration testbench
// Drives setpoint/feedback samples through a set of gain, divisor and limit
// settings with random idling on both channels, including a long result
// stall and an integral build-up run, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_pid_conditional_integration;

    logic                             aclk;
    logic                             aresetn;
    logic                             s_valid;
    logic                             s_ready;
    pidci_pkg::in_t                   s_data;
    logic                             m_valid;
    logic                             m_ready;
    pidci_pkg::out_t                  m_data;
    logic                             cfg_wr_en;
    logic [pidci_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [pidci_pkg::CFG_DATA_W-1:0] cfg_data;

    int mismatch_total;
    int drives_outstanding;

    // shared between the two stimulus processes
    bit no_idle;   // both sides run back to back while set
    bit hold_req;  // ask the result side for one long hold-off

    pid_conditional_integration i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    pidci_checker i_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_data             (s_data),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_data             (m_data),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .mismatch_total     (mismatch_total),
        .drives_outstanding (drives_outstanding)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Offer one sample after a random gap and hold it until it is accepted.
    // A zero gap keeps valid high straight into the next sample.
    task automatic send_sample(input logic signed [pidci_pkg::SAMPLE_W-1:0] sp,
                               input logic signed [pidci_pkg::SAMPLE_W-1:0] fb);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{setpoint: sp, feedback: fb};
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // Drop valid and hold until every predicted drive has come back. Let a
    // clock edge pass first so the checker's count includes the last transaction.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (drives_outstanding != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // Write all five registers on consecutive cycles; the block must be idle.
    task automatic program_loop(input logic [pidci_pkg::GAIN_W-1:0] kp,
                                input logic [pidci_pkg::GAIN_W-1:0] ki,
                                input logic [pidci_pkg::GAIN_W-1:0] kd,
                                input logic [pidci_pkg::DIV_W-1:0]  dv,
                                input logic [pidci_pkg::LIM_W-1:0]  lim);
        logic [pidci_pkg::CFG_DATA_W-1:0] vals [5];
        logic [pidci_pkg::CFG_IDX_W-1:0]  idxs [5];
        vals = '{kp, ki, kd, dv, {1'b0, lim}};
        idxs = '{pidci_pkg::REG_KP_GAIN, pidci_pkg::REG_KI_GAIN, pidci_pkg::REG_KD_GAIN,
                 pidci_pkg::REG_OUT_DIVISOR, pidci_pkg::REG_MAX_OUTPUT};
        for (int r = 0; r < 5; r++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idxs[r];
            cfg_data  <= vals[r];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Gains: half of the picks are moderate Q8.8 values so drives stay inside
    // the limit, the rest are full-range and extreme picks.
    function automatic logic [pidci_pkg::GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom);
            1:       return 16'h8000;
            2:       return 16'h7FFF;
            default: return 16'(int'($urandom_range(0, 2047)) - 1024);
        endcase
    endfunction

    // Result side: random ready gaps per transaction, one long hold-off on
    // request so the block backs up and stalls its input.
    initial begin : result_side
        int gap;
        m_ready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 15);
            if (hold_req) begin
                gap      = 300;
                hold_req = 1'b0;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    initial begin : stimulus
        logic signed [pidci_pkg::SAMPLE_W-1:0] sp;
        logic signed [pidci_pkg::SAMPLE_W-1:0] fb;
        logic [pidci_pkg::GAIN_W-1:0]          kp, ki, kd;
        logic [pidci_pkg::DIV_W-1:0]           dv;
        logic [pidci_pkg::LIM_W-1:0]           lim;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        no_idle   = 1'b0;
        hold_req  = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: unity proportional gain, full limit. Cover sample
        // extremes and the limit being hit exactly from both sides.
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd32767, -16'sd32768);
        send_sample(-16'sd32768, 16'sd32767);
        send_sample(16'sd32767, 16'sd0);
        send_sample(-16'sd32767, 16'sd0);
        send_sample(16'sd32766, 16'sd0);
        send_sample(-16'sd32768, -16'sd32768);
        wait_idle();

        // Zero divisor behaves as one; small limit so the clamp kicks in.
        program_loop(16'd256, 16'd256, 16'd256, 16'd0, 15'd1000);
        send_sample(16'sd1, 16'sd0);
        send_sample(16'sd2, 16'sd0);
        send_sample(-16'sd3, 16'sd0);
        send_sample(16'sd0, 16'sd0);
        wait_idle();

        // Zero limit: every step clamps to zero.
        program_loop(16'd256, 16'd0, 16'd0, 16'd256, 15'd0);
        send_sample(16'sd5, 16'sd0);
        send_sample(16'sd0, 16'sd0);
        send_sample(-16'sd5, 16'sd3);
        wait_idle();

        // Gain and divisor extremes.
        program_loop(16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF, 15'd32767);
        send_sample(16'sd32767, -16'sd32768);
        send_sample(-16'sd32768, 16'sd32767);
        send_sample(16'sd100, -16'sd100);
        send_sample(16'sd0, 16'sd0);
        wait_idle();
        program_loop(16'h7FFF, 16'h8000, 16'h7FFF, 16'd1, 15'd32767);
        send_sample(16'sd1, 16'sd0);
        send_sample(-16'sd1, 16'sd0);
        send_sample(16'sd32767, -16'sd32768);
        wait_idle();

        // Random phases: fresh settings each phase, every fourth phase
        // without idling, one phase with a long result stall.
        for (int ph = 0; ph < 11; ph++) begin
            wait_idle();
            no_idle = (ph % 4 == 3);
            kp = pick_gain();
            ki = pick_gain();
            kd = pick_gain();
            case ($urandom_range(0, 3))
                0:       dv = 16'd1;
                1:       dv = 16'd256;
                2:       dv = pidci_pkg::DIV_W'($urandom_range(1, 65535));
                default: dv = pidci_pkg::DIV_W'($urandom_range(256, 8192));
            endcase
            case ($urandom_range(0, 7))
                0:       lim = 15'd0;
                1:       lim = 15'd32767;
                default: lim = pidci_pkg::LIM_W'($urandom_range(1, 32767));
            endcase
            program_loop(kp, ki, kd, dv, lim);
            for (int k = 0; k < 100; k++) begin
                if (ph == 5 && k == 20) hold_req = 1'b1;
                case ($urandom_range(0, 3))
                    0: begin
                        sp = 16'($urandom);
                        fb = 16'($urandom);
                    end
                    1: begin
                        sp = 16'($urandom);
                        fb = sp + 16'(int'($urandom_range(0, 128)) - 64);
                    end
                    default: begin
                        sp = 16'(int'($urandom_range(0, 1023)) - 512);
                        fb = 16'(int'($urandom_range(0, 1023)) - 512);
                    end
                endcase
                send_sample(sp, fb);
            end
        end

        // Integral build-up: with all gains zero nothing clamps, so the
        // largest error accumulates back to back.
        wait_idle();
        no_idle = 1'b1;
        program_loop(16'd0, 16'd0, 16'd0, 16'd256, 15'd32767);
        for (int k = 0; k < 100; k++)
            send_sample(16'sd32767, -16'sd32768);
        wait_idle();
        // Read the built-up integral back through a small integral gain.
        no_idle = 1'b0;
        program_loop(16'd0, 16'd1, 16'd0, 16'hFFFF, 15'd32767);
        send_sample(16'sd0, 16'sd0);
        send_sample(-16'sd32768, 16'sd32767);
        send_sample(16'sd0, 16'sd0);

        wait_idle();
        repeat (40) @(posedge aclk);
        if (mismatch_total == 0 && drives_outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin : watchdog
        #100000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
